// File: rtl/gfba_pkg.sv
// Shared constants, codes and types of the grouped free-block allocator.
// No dependencies; used by gfba_ctrl, gfba_dp and the top level.
package gfba_pkg;

  localparam int GROUP_SIZE  = 128;
  localparam int MAX_GROUPS  = 64;
  localparam int BLOCK_BITS  = 24;

  localparam int STORE_DEPTH = MAX_GROUPS * GROUP_SIZE;
  localparam int IDX_W       = $clog2(GROUP_SIZE);
  localparam int CNT_W       = $clog2(GROUP_SIZE + 1);
  localparam int GP_W        = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS + 1) : 1;
  localparam int GIDX_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int SA_W        = $clog2(STORE_DEPTH);
  localparam int STATUS_W    = 2;
  localparam int SCOUNT_W    = 8;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_STORE_FULL = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef logic [3:0] act_t;

  localparam act_t ACT_NONE        = 4'd0;
  localparam act_t ACT_ALLOC_EMPTY = 4'd1;
  localparam act_t ACT_ALLOC_SENT  = 4'd2;
  localparam act_t ACT_ALLOC_POP   = 4'd3;
  localparam act_t ACT_GRAB        = 4'd4;
  localparam act_t ACT_FREE_ZERO   = 4'd5;
  localparam act_t ACT_FREE_FULL   = 4'd6;
  localparam act_t ACT_SEED        = 4'd7;
  localparam act_t ACT_FREE_PUSH   = 4'd8;
  localparam act_t ACT_SPILL_START = 4'd9;
  localparam act_t ACT_SPILL_STEP  = 4'd10;
  localparam act_t ACT_SPILL_END   = 4'd11;
  localparam act_t ACT_REFILL_STEP = 4'd12;
  localparam act_t ACT_REFILL_END  = 4'd13;

  typedef struct packed {
    act_t act;
    logic capture;
  } gfba_cmd_t;

  typedef struct packed {
    logic is_free;
    logic blk_zero;
    logic count_zero;
    logic count_one;
    logic count_full;
    logic gp_zero;
    logic gp_full;
    logic top_zero;
    logic sweep_done;
  } gfba_stat_t;

endpackage

// File: rtl/gfba_dp.sv
// Datapath of the grouped free-block allocator: top stack, group store,
// counters, copy sweep and result register. Depends on gfba_pkg.
module gfba_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  gfba_pkg::gfba_cmd_t              cmd,
  input  logic                             in_op,
  input  logic [gfba_pkg::BLOCK_BITS-1:0]  in_block_number,
  output gfba_pkg::gfba_stat_t             stat,
  output logic [gfba_pkg::BLOCK_BITS-1:0]  out_granted_block,
  output logic [gfba_pkg::STATUS_W-1:0]    out_status,
  output logic [gfba_pkg::SCOUNT_W-1:0]    out_stack_count
);

  logic [gfba_pkg::BLOCK_BITS-1:0] stack_mem [gfba_pkg::GROUP_SIZE];
  logic [gfba_pkg::BLOCK_BITS-1:0] store_mem [gfba_pkg::STORE_DEPTH];

  logic [gfba_pkg::BLOCK_BITS-1:0] stack_rdata_r;
  logic [gfba_pkg::BLOCK_BITS-1:0] store_rdata_r;

  logic [gfba_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [gfba_pkg::GP_W-1:0]       gp_r, gp_nxt;
  logic [gfba_pkg::CNT_W-1:0]      k_r, k_nxt;
  logic                            pend_r, pend_nxt;
  logic [gfba_pkg::IDX_W-1:0]      pidx_r, pidx_nxt;
  logic                            req_op_r, req_op_nxt;
  logic [gfba_pkg::BLOCK_BITS-1:0] req_blk_r, req_blk_nxt;
  logic [gfba_pkg::BLOCK_BITS-1:0] res_blk_r, res_blk_nxt;
  logic [gfba_pkg::STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [gfba_pkg::CNT_W-1:0]      res_count_r, res_count_nxt;

  logic                            stack_re, stack_we;
  logic [gfba_pkg::IDX_W-1:0]      stack_raddr, stack_waddr;
  logic [gfba_pkg::BLOCK_BITS-1:0] stack_wdata;
  logic                            store_re, store_we;
  logic [gfba_pkg::SA_W-1:0]       store_raddr, store_waddr, store_base;
  logic [gfba_pkg::GIDX_W-1:0]     gidx;
  logic [gfba_pkg::CNT_W-1:0]      count_dec;
  logic [gfba_pkg::GP_W-1:0]       gp_dec;
  logic                            sweep_step;

  assign count_dec  = count_r - gfba_pkg::CNT_W'(1);
  assign gp_dec     = gp_r - gfba_pkg::GP_W'(1);
  assign gidx       = (cmd.act == gfba_pkg::ACT_REFILL_STEP) ? gp_dec[gfba_pkg::GIDX_W-1:0]
                                                             : gp_r[gfba_pkg::GIDX_W-1:0];
  assign store_base = gfba_pkg::SA_W'(gidx) * gfba_pkg::SA_W'(gfba_pkg::GROUP_SIZE);
  assign sweep_step = (cmd.act == gfba_pkg::ACT_SPILL_STEP) ||
                      (cmd.act == gfba_pkg::ACT_REFILL_STEP);

  always_comb begin
    stack_re       = 1'b0;
    stack_raddr    = count_dec[gfba_pkg::IDX_W-1:0];
    stack_we       = 1'b0;
    stack_waddr    = count_r[gfba_pkg::IDX_W-1:0];
    stack_wdata    = req_blk_r;
    store_re       = 1'b0;
    store_raddr    = store_base + gfba_pkg::SA_W'(k_r[gfba_pkg::IDX_W-1:0]);
    store_we       = 1'b0;
    store_waddr    = store_base + gfba_pkg::SA_W'(pidx_r);
    count_nxt      = count_r;
    gp_nxt         = gp_r;
    k_nxt          = k_r;
    pend_nxt       = pend_r;
    pidx_nxt       = pidx_r;
    req_op_nxt     = req_op_r;
    req_blk_nxt    = req_blk_r;
    res_blk_nxt    = res_blk_r;
    res_status_nxt = res_status_r;
    res_count_nxt  = res_count_r;

    if (cmd.capture) begin
      req_op_nxt  = in_op;
      req_blk_nxt = in_block_number;
      stack_re    = 1'b1;
    end

    // shared copy sweep: read at k, write the entry read on the previous step
    if (sweep_step) begin
      if (k_r < gfba_pkg::CNT_W'(gfba_pkg::GROUP_SIZE)) begin
        pend_nxt = 1'b1;
        pidx_nxt = k_r[gfba_pkg::IDX_W-1:0];
        k_nxt    = k_r + gfba_pkg::CNT_W'(1);
      end else begin
        pend_nxt = 1'b0;
      end
    end

    case (cmd.act)
      gfba_pkg::ACT_ALLOC_EMPTY: begin
        res_blk_nxt    = '0;
        res_status_nxt = gfba_pkg::STATUS_NO_SPACE;
        res_count_nxt  = count_r;
      end
      gfba_pkg::ACT_ALLOC_SENT: begin
        count_nxt      = '0;
        res_blk_nxt    = '0;
        res_status_nxt = gfba_pkg::STATUS_NO_SPACE;
        res_count_nxt  = '0;
      end
      gfba_pkg::ACT_ALLOC_POP: begin
        count_nxt      = count_dec;
        res_blk_nxt    = stack_rdata_r;
        res_status_nxt = gfba_pkg::STATUS_OK;
        res_count_nxt  = count_dec;
      end
      gfba_pkg::ACT_GRAB: begin
        req_blk_nxt = stack_rdata_r;
        k_nxt       = '0;
        pend_nxt    = 1'b0;
      end
      gfba_pkg::ACT_FREE_ZERO: begin
        res_blk_nxt    = '0;
        res_status_nxt = gfba_pkg::STATUS_OK;
        res_count_nxt  = count_r;
      end
      gfba_pkg::ACT_FREE_FULL: begin
        res_blk_nxt    = '0;
        res_status_nxt = gfba_pkg::STATUS_STORE_FULL;
        res_count_nxt  = count_r;
      end
      gfba_pkg::ACT_SEED: begin
        stack_we    = 1'b1;
        stack_waddr = '0;
        stack_wdata = '0;
        count_nxt   = gfba_pkg::CNT_W'(1);
      end
      gfba_pkg::ACT_FREE_PUSH: begin
        stack_we       = 1'b1;
        count_nxt      = count_r + gfba_pkg::CNT_W'(1);
        res_blk_nxt    = '0;
        res_status_nxt = gfba_pkg::STATUS_OK;
        res_count_nxt  = count_r + gfba_pkg::CNT_W'(1);
      end
      gfba_pkg::ACT_SPILL_START: begin
        k_nxt    = '0;
        pend_nxt = 1'b0;
      end
      gfba_pkg::ACT_SPILL_STEP: begin
        stack_re    = (k_r < gfba_pkg::CNT_W'(gfba_pkg::GROUP_SIZE));
        stack_raddr = k_r[gfba_pkg::IDX_W-1:0];
        store_we    = pend_r;
      end
      gfba_pkg::ACT_SPILL_END: begin
        gp_nxt    = gp_r + gfba_pkg::GP_W'(1);
        count_nxt = '0;
      end
      gfba_pkg::ACT_REFILL_STEP: begin
        store_re    = (k_r < gfba_pkg::CNT_W'(gfba_pkg::GROUP_SIZE));
        stack_we    = pend_r;
        stack_waddr = pidx_r;
        stack_wdata = store_rdata_r;
      end
      gfba_pkg::ACT_REFILL_END: begin
        gp_nxt         = gp_dec;
        count_nxt      = gfba_pkg::CNT_W'(gfba_pkg::GROUP_SIZE);
        res_blk_nxt    = req_blk_r;
        res_status_nxt = gfba_pkg::STATUS_OK;
        res_count_nxt  = gfba_pkg::CNT_W'(gfba_pkg::GROUP_SIZE);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
    if (stack_re) stack_rdata_r <= stack_mem[stack_raddr];
  end

  always_ff @(posedge clk) begin
    if (store_we) store_mem[store_waddr] <= stack_rdata_r;
    if (store_re) store_rdata_r <= store_mem[store_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      gp_r    <= '0;
      k_r     <= '0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      gp_r    <= gp_nxt;
      k_r     <= k_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r       <= pidx_nxt;
    req_op_r     <= req_op_nxt;
    req_blk_r    <= req_blk_nxt;
    res_blk_r    <= res_blk_nxt;
    res_status_r <= res_status_nxt;
    res_count_r  <= res_count_nxt;
  end

  always_comb begin
    stat.is_free    = (req_op_r == gfba_pkg::OP_FREE);
    stat.blk_zero   = (req_blk_r == '0);
    stat.count_zero = (count_r == '0);
    stat.count_one  = (count_r == gfba_pkg::CNT_W'(1));
    stat.count_full = (count_r >= gfba_pkg::CNT_W'(gfba_pkg::GROUP_SIZE));
    stat.gp_zero    = (gp_r == '0);
    stat.gp_full    = (gp_r >= gfba_pkg::GP_W'(gfba_pkg::MAX_GROUPS));
    stat.top_zero   = (stack_rdata_r == '0);
    stat.sweep_done = (k_r == gfba_pkg::CNT_W'(gfba_pkg::GROUP_SIZE)) && !pend_r;
  end

  assign out_granted_block = res_blk_r;
  assign out_status        = res_status_r;
  assign out_stack_count   = gfba_pkg::SCOUNT_W'(res_count_r);

endmodule

// File: rtl/gfba_ctrl.sv
// Controller of the grouped free-block allocator: request handshake,
// sequencing of spill and refill sweeps, result valid. Depends on gfba_pkg.
module gfba_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  gfba_pkg::gfba_stat_t stat,
  output gfba_pkg::gfba_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_SPILL  = 3'd2;
  localparam logic [2:0] ST_SPUSH  = 3'd3;
  localparam logic [2:0] ST_REFILL = 3'd4;
  localparam logic [2:0] ST_RFIN   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       emit;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt   = state_r;
    cmd.act     = gfba_pkg::ACT_NONE;
    cmd.capture = 1'b0;
    emit        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!stat.is_free) begin
          if (stat.count_zero) begin
            if (out_free) begin
              cmd.act   = gfba_pkg::ACT_ALLOC_EMPTY;
              emit      = 1'b1;
              state_nxt = ST_IDLE;
            end
          end else if (stat.top_zero) begin
            if (out_free) begin
              cmd.act   = gfba_pkg::ACT_ALLOC_SENT;
              emit      = 1'b1;
              state_nxt = ST_IDLE;
            end
          end else if (stat.count_one && !stat.gp_zero) begin
            cmd.act   = gfba_pkg::ACT_GRAB;
            state_nxt = ST_REFILL;
          end else if (out_free) begin
            cmd.act   = gfba_pkg::ACT_ALLOC_POP;
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          if (stat.blk_zero) begin
            if (out_free) begin
              cmd.act   = gfba_pkg::ACT_FREE_ZERO;
              emit      = 1'b1;
              state_nxt = ST_IDLE;
            end
          end else if (stat.count_full && stat.gp_full) begin
            if (out_free) begin
              cmd.act   = gfba_pkg::ACT_FREE_FULL;
              emit      = 1'b1;
              state_nxt = ST_IDLE;
            end
          end else if (stat.count_zero) begin
            // lay down the end sentinel, then push on the next pass
            cmd.act = gfba_pkg::ACT_SEED;
          end else if (stat.count_full) begin
            cmd.act   = gfba_pkg::ACT_SPILL_START;
            state_nxt = ST_SPILL;
          end else if (out_free) begin
            cmd.act   = gfba_pkg::ACT_FREE_PUSH;
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SPILL: begin
        if (stat.sweep_done) begin
          cmd.act   = gfba_pkg::ACT_SPILL_END;
          state_nxt = ST_SPUSH;
        end else begin
          cmd.act = gfba_pkg::ACT_SPILL_STEP;
        end
      end
      ST_SPUSH: begin
        if (out_free) begin
          cmd.act   = gfba_pkg::ACT_FREE_PUSH;
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_REFILL: begin
        if (stat.sweep_done) begin
          state_nxt = ST_RFIN;
        end else begin
          cmd.act = gfba_pkg::ACT_REFILL_STEP;
        end
      end
      ST_RFIN: begin
        if (out_free) begin
          cmd.act   = gfba_pkg::ACT_REFILL_END;
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = emit | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/grouped_free_block_allocator.sv
// Grouped free-block allocator, top level. Depends on gfba_pkg, gfba_ctrl, gfba_dp.
// An ordinary alloc or free is captured in IDLE, with a registered read of the top-stack
//   memory, and answered from EXEC; in_stall holds off a new request until back in IDLE.
// A spill or refill copies one whole group between the top stack and the group store.
// A first free on an empty stack lays down the sentinel before it pushes the block.
// Reset (synchronous, rst_n low) clears counters and control; memories are not cleared.
module grouped_free_block_allocator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_op,
  input  logic [gfba_pkg::BLOCK_BITS-1:0]  in_block_number,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [gfba_pkg::BLOCK_BITS-1:0]  out_granted_block,
  output logic [gfba_pkg::STATUS_W-1:0]    out_status,
  output logic [gfba_pkg::SCOUNT_W-1:0]    out_stack_count
);

  // Command and status between the sequencer and the storage datapath.
  gfba_pkg::gfba_cmd_t  cmd;
  gfba_pkg::gfba_stat_t stat;

  // Sequencer: takes one request at a time, drives the copy sweeps and
  // holds the result valid until the downstream side takes it.
  gfba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: top stack and group store memories, counts, result register.
  gfba_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_op             (in_op),
    .in_block_number   (in_block_number),
    .stat              (stat),
    .out_granted_block (out_granted_block),
    .out_status        (out_status),
    .out_stack_count   (out_stack_count)
  );

`ifndef SYNTHESIS
  // A taken request blocks the input for at least the following cycle.
  a_busy_after_request : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while previous one still in progress");

  // The reported stack occupancy never exceeds one group.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_stack_count <= gfba_pkg::SCOUNT_W'(gfba_pkg::GROUP_SIZE)))
    else $error("stack count beyond group size");

  // A refused free only happens with a full top stack.
  a_refuse_full : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == gfba_pkg::STATUS_STORE_FULL)) |->
    (out_stack_count == gfba_pkg::SCOUNT_W'(gfba_pkg::GROUP_SIZE)))
    else $error("free refused while top stack not full");

  // A granted block always carries an ok status.
  a_grant_ok : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_granted_block != '0)) |-> (out_status == gfba_pkg::STATUS_OK))
    else $error("block granted with failing status");
`endif

endmodule
